### hdl/dorc_pkg.sv
// Shared types, constants and helpers for the dark offset and response correction core.
// No dependencies; every other file in hdl/ imports this package.
package dorc_pkg;

    localparam int DARK_SAMPLES_DEF = 1000;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int SAMPLE_W  = 16;
    localparam int WAVE_W    = 20;
    localparam int SENS_W    = 20;
    localparam int EXP_W     = 32;
    localparam int VALUE_W   = 40;
    localparam int SUM_W     = 28;
    localparam int DIVISOR_W = SENS_W + EXP_W;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [EXP_W-1:0]   EXP_RESET       = 32'd16777216;
    localparam logic [WAVE_W-1:0]  WAVE_LOW_RESET  = 20'd43000;
    localparam logic [WAVE_W-1:0]  WAVE_HIGH_RESET = 20'd60000;
    localparam logic [SENS_W-1:0]  SENS_ONE        = 20'h10000;
    localparam logic [VALUE_W-1:0] VALUE_MAX       = {VALUE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_HIGH = 2'd2;

    localparam logic OP_DARK  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] signal;
        logic [SENS_W-1:0]   sens;
        logic                last;
    } t_job;

    function automatic logic [SAMPLE_W-1:0] swap16(input logic [SAMPLE_W-1:0] s);
        return {s[7:0], s[15:8]};
    endfunction

endpackage

### hdl/dark_offset_response_correction_core.sv
// Top level of the dark offset and response correction core: configuration registers
// and the front end, job queue and divider back end. Depends on dorc_pkg.
//
// Dark beats are summed as they arrive. The beat that completes the dark set starts a
// reciprocal multiplication for the mean, during which input is stalled. A pixel beat
// in the wavelength window is pushed into the job queue; the back end then takes it
// through divisor product, range check, 40-step restoring divider and result load,
// skipping the divider when the signal is zero or the quotient saturates, and takes
// no new job until the result is loaded. Out-of-window pixels and dark beats pass at
// one per cycle while the queue has room and no mean is being formed. The user must
// write configuration only while idle; the block itself does not enforce it.
module dark_offset_response_correction_core import dorc_pkg::*; #(
    parameter int DARK_SAMPLES = DARK_SAMPLES_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic [WAVE_W-1:0]    i_wavelength,
    input  logic [SENS_W-1:0]    i_sensitivity,
    input  logic                 i_row_end,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [VALUE_W-1:0]   o_value,
    output logic                 o_saturated,
    output logic                 o_last_in_row,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [EXP_W-1:0]     i_cfg_data
);

    logic [EXP_W-1:0]  r_exposure;
    logic [WAVE_W-1:0] r_wave_low;
    logic [WAVE_W-1:0] r_wave_high;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job push_job;
    t_job pop_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure  <= EXP_RESET;
            r_wave_low  <= WAVE_LOW_RESET;
            r_wave_high <= WAVE_HIGH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_EXPOSURE:  r_exposure  <= i_cfg_data;
                CFG_WAVE_LOW:  r_wave_low  <= i_cfg_data[WAVE_W-1:0];
                CFG_WAVE_HIGH: r_wave_high <= i_cfg_data[WAVE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dorc_front #(
        .DARK_SAMPLES(DARK_SAMPLES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_sample     (i_sample),
        .i_wavelength (i_wavelength),
        .i_sensitivity(i_sensitivity),
        .i_row_end    (i_row_end),
        .i_wave_low   (r_wave_low),
        .i_wave_high  (r_wave_high),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_job        (push_job)
    );

    dorc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_job  (pop_job),
        .i_pop  (q_pop)
    );

    dorc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_exposure   (r_exposure),
        .i_job_valid  (q_valid),
        .i_job        (pop_job),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_saturated  (o_saturated),
        .o_last_in_row(o_last_in_row)
    );

endmodule

### hdl/dorc_front.sv
// Front end: accepts input beats, accumulates the dark baseline, filters pixels
// by wavelength window and forms pixel jobs. Depends on dorc_pkg.
module dorc_front import dorc_pkg::*; #(
    parameter int DARK_SAMPLES = DARK_SAMPLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [WAVE_W-1:0]   i_wavelength,
    input  logic [SENS_W-1:0]   i_sensitivity,
    input  logic                i_row_end,
    input  logic [WAVE_W-1:0]   i_wave_low,
    input  logic [WAVE_W-1:0]   i_wave_high,
    input  logic                i_q_full,
    output logic                o_push,
    output t_job                o_job
);

    localparam int CNT_W      = $clog2(DARK_SAMPLES + 1);
    localparam int MEAN_SHIFT = SUM_W + $clog2(DARK_SAMPLES);
    localparam logic [SUM_W:0] MEAN_RECIP =
        (SUM_W + 1)'(((64'd1 << MEAN_SHIFT) + 64'(DARK_SAMPLES) - 64'd1)
                     / 64'(DARK_SAMPLES));

    logic [SUM_W-1:0]    r_dark_sum;
    logic [CNT_W-1:0]    r_dark_count;
    logic [SAMPLE_W-1:0] r_dark_level;
    logic                r_mean_busy;

    logic                accept;
    logic [SAMPLE_W-1:0] swapped;
    logic                in_window;
    logic                dark_take;
    logic [SUM_W-1:0]    n_dark_sum;
    logic [CNT_W-1:0]    n_dark_count;
    logic [2*SUM_W:0]    mean_prod;

    assign o_in_stall = r_mean_busy | i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign swapped    = swap16(i_sample);
    assign in_window  = (i_wavelength >= i_wave_low) && (i_wavelength <= i_wave_high);

    assign o_push       = accept && (i_operation == OP_PIXEL) && in_window;
    assign o_job.signal = (swapped > r_dark_level) ? swapped - r_dark_level : '0;
    assign o_job.sens   = (i_sensitivity == '0) ? SENS_ONE : i_sensitivity;
    assign o_job.last   = i_row_end;

    assign dark_take    = accept && (i_operation == OP_DARK)
                          && (r_dark_count < CNT_W'(DARK_SAMPLES));
    assign n_dark_sum   = r_dark_sum + SUM_W'(swapped);
    assign n_dark_count = r_dark_count + CNT_W'(1);

    assign mean_prod = r_dark_sum * MEAN_RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_sum   <= '0;
            r_dark_count <= '0;
            r_dark_level <= '0;
            r_mean_busy  <= 1'b0;
        end else begin
            if (dark_take) begin
                r_dark_sum   <= n_dark_sum;
                r_dark_count <= n_dark_count;
                if (n_dark_count == CNT_W'(DARK_SAMPLES)) begin
                    r_mean_busy <= 1'b1;
                end
            end
            if (r_mean_busy) begin
                r_mean_busy  <= 1'b0;
                r_dark_level <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dark_count <= CNT_W'(DARK_SAMPLES))
        else $error("dark count beyond sample total");

    a_mean_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mean_busy) |-> r_dark_count == CNT_W'(DARK_SAMPLES))
        else $error("mean division started before the last dark sample");

    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mean_busy |-> !o_push && !dark_take)
        else $error("beat taken during mean division");

endmodule

### hdl/dorc_queue.sv
// Short job queue between the front end and the divider back end.
// Depends on dorc_pkg for the job type.
module dorc_queue import dorc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

### hdl/dorc_back.sv
// Back end: forms the divisor, runs the restoring divider and holds the result beat.
// Depends on dorc_pkg.
module dorc_back import dorc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [EXP_W-1:0]   i_exposure,
    input  logic               i_job_valid,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_saturated,
    output logic               o_last_in_row
);

    localparam int STEP_W = $clog2(VALUE_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [SAMPLE_W-1:0]  r_signal;
    logic [SENS_W-1:0]    r_sens;
    logic                 r_last;
    logic [DIVISOR_W-1:0] r_divisor;
    logic [DIVISOR_W-1:0] r_rem;
    logic [VALUE_W-1:0]   r_quo;
    logic                 r_sat;
    logic [STEP_W-1:0]    r_step;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_value;
    logic                 r_sat_out;
    logic                 r_last_out;

    logic [DIVISOR_W-1:0] n_divisor;
    logic [DIVISOR_W-1:0] scaled;
    logic [DIVISOR_W:0]   trial;
    logic                 div_ge;
    logic [DIVISOR_W-1:0] n_rem;

    assign o_pop         = (r_state == S_IDLE) && i_job_valid;
    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_saturated   = r_sat_out;
    assign o_last_in_row = r_last_out;

    assign n_divisor = r_sens * i_exposure;
    assign scaled    = DIVISOR_W'({r_signal, {FRAC_W{1'b0}}});
    assign trial     = {r_rem, 1'b0};
    assign div_ge    = trial >= {1'b0, r_divisor};
    assign n_rem     = div_ge ? DIVISOR_W'(trial - {1'b0, r_divisor}) : DIVISOR_W'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_signal <= i_job.signal;
                        r_sens   <= i_job.sens;
                        r_last   <= i_job.last;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_divisor <= n_divisor;
                    r_state   <= S_CHK;
                end
                S_CHK: begin
                    if (r_signal == '0) begin
                        r_quo   <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_DONE;
                    end else if (scaled >= r_divisor) begin
                        r_quo   <= VALUE_MAX;
                        r_sat   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_rem   <= scaled;
                        r_quo   <= '0;
                        r_sat   <= 1'b0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= {r_quo[VALUE_W-2:0], div_ge};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(VALUE_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_value     <= r_quo;
                        r_sat_out   <= r_sat;
                        r_last_out  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_sat_out |-> r_value == VALUE_MAX)
        else $error("saturated beat without full-scale value");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_divisor)
        else $error("divider remainder not below divisor");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_divisor != '0)
        else $error("division entered with zero divisor");

endmodule
